FILE: hw/rtl/lkl_pkg.sv
// Shared types and constants for the LRU key list.
package lkl_pkg;

  // List geometry
  localparam int LIST_DEPTH = 8;
  localparam int KEY_W      = 8;
  localparam int OUTCOME_W  = 2;
  localparam int OCC_W      = 4;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  // Stream widths (fields packed from bit 0, padded to whole bytes)
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 16;

  // Result outcome codes
  typedef enum logic [OUTCOME_W-1:0] {
    OC_INSERTED     = 2'd0,
    OC_MOVED        = 2'd1,
    OC_ALREADY_REAR = 2'd2,
    OC_EVICTED      = 2'd3
  } outcome_e;

  // Command broadcast to every cell
  typedef enum logic [1:0] {
    CMD_IDLE   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_MOVE   = 2'd2,
    CMD_EVICT  = 2'd3
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e        cmd;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

  // Per-cell lookup status
  typedef struct packed {
    logic match;
    logic rear_hit;
  } cell_stat_t;

endpackage

FILE: hw/rtl/lkl_cell.sv
// One slot of the LRU key list: holds a key, compares it and shifts toward the front.
module lkl_cell
  import lkl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic             prev_valid_i,
  input  logic             next_valid_i,
  input  logic [KEY_W-1:0] next_key_i,
  input  logic             seen_i,
  output logic             seen_o,
  output logic             valid_o,
  output logic [KEY_W-1:0] key_o,
  output cell_stat_t       stat_o
);

  logic             valid_q, valid_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic             match;
  logic             is_rear;

  // Lookup: compare, and pass on whether the hit lies at or before this slot
  assign match    = valid_q && (key_q == ctrl_i.key);
  assign is_rear  = valid_q && !next_valid_i;
  assign seen_o   = seen_i | match;

  assign stat_o.match    = match;
  assign stat_o.rear_hit = match & is_rear;
  assign valid_o         = valid_q;
  assign key_o           = key_q;

  // Update: load the new key or take the neighbor's key
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    case (ctrl_i.cmd)
      CMD_INSERT: begin
        if (!valid_q && prev_valid_i) begin
          valid_d = 1'b1;
          key_d   = ctrl_i.key;
        end
      end
      CMD_MOVE: begin
        // slots from the hit up to the rear close the gap
        if (valid_q && seen_o) begin
          key_d = is_rear ? ctrl_i.key : next_key_i;
        end
      end
      CMD_EVICT: begin
        if (valid_q) begin
          key_d = is_rear ? ctrl_i.key : next_key_i;
        end
      end
      default: begin
        valid_d = valid_q;
        key_d   = key_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

FILE: hw/rtl/lru_key_list.sv
// LRU key list top level: row of key cells, access decision and result register.
//
//  channel  | dir | tdata                                   | tuser
//  ---------+-----+-----------------------------------------+--------------
//  s_axis   | in  | [7:0] key                               | -
//  m_axis   | out | [7:0] evicted_key, [11:8] occupancy     | [1:0] outcome
//
// One access per clock while s_axis_tready is high: every cell compares the key in
// parallel; on acceptance an insert fills the first free slot or a move or eviction
// shifts the row one slot. The output register shows the result in the next cycle.
// s_axis_tready stays high while the output register is empty or being taken.
// Reset empties the list (all cell valid bits cleared, held count zero).
module lru_key_list
  import lkl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [7:0] key
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // [7:0] evicted_key, [11:8] occupancy
  output logic [OUTCOME_W-1:0] m_axis_tuser    // [1:0] outcome
);

  logic                  seen_w  [LIST_DEPTH+1];
  logic [LIST_DEPTH-1:0] valid_w;
  logic [LIST_DEPTH-1:0] match_w;
  logic [LIST_DEPTH-1:0] rear_w;
  logic [KEY_W-1:0]      key_w   [LIST_DEPTH];
  cell_stat_t            stat_w  [LIST_DEPTH];
  cell_ctrl_t            ctrl;

  logic [CNT_W-1:0]      count_q, count_d;
  logic                  accept;
  logic                  found, rear_hit, full;
  outcome_e              outcome;

  logic                  out_valid_q;
  outcome_e              outcome_q;
  logic [KEY_W-1:0]      evicted_q, evicted_d;
  logic [OCC_W-1:0]      occ_q;

  // Cell row
  assign seen_w[0] = 1'b0;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic             prev_valid;
    logic             next_valid;
    logic [KEY_W-1:0] next_key;

    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_mid
      assign prev_valid = valid_w[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_key   = '0;
    end else begin : g_inner
      assign next_valid = valid_w[i+1];
      assign next_key   = key_w[i+1];
    end

    lkl_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_valid_i (prev_valid),
      .next_valid_i (next_valid),
      .next_key_i   (next_key),
      .seen_i       (seen_w[i]),
      .seen_o       (seen_w[i+1]),
      .valid_o      (valid_w[i]),
      .key_o        (key_w[i]),
      .stat_o       (stat_w[i])
    );

    assign match_w[i] = stat_w[i].match;
    assign rear_w[i]  = stat_w[i].rear_hit;
  end

  // Access decision
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign found         = seen_w[LIST_DEPTH];
  assign rear_hit      = |rear_w;
  assign full          = valid_w[LIST_DEPTH-1];

  always_comb begin
    if (found) begin
      outcome = rear_hit ? OC_ALREADY_REAR : OC_MOVED;
    end else begin
      outcome = full ? OC_EVICTED : OC_INSERTED;
    end
  end

  always_comb begin
    ctrl.key = s_axis_tdata[KEY_W-1:0];
    ctrl.cmd = CMD_IDLE;
    if (accept) begin
      case (outcome)
        OC_INSERTED: ctrl.cmd = CMD_INSERT;
        OC_MOVED:    ctrl.cmd = CMD_MOVE;
        OC_EVICTED:  ctrl.cmd = CMD_EVICT;
        default:     ctrl.cmd = CMD_IDLE;
      endcase
    end
  end

  // Held count and evicted key
  assign count_d   = (outcome == OC_INSERTED) ? count_q + CNT_W'(1) : count_q;
  assign evicted_d = (outcome == OC_EVICTED) ? key_w[0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      outcome_q <= outcome;
      evicted_q <= evicted_d;
      occ_q     <= OCC_W'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = outcome_q;
  assign m_axis_tdata  = {{(M_TDATA_W - KEY_W - OCC_W){1'b0}}, occ_q, evicted_q};

`ifndef SYNTHESIS
  logic [LIST_DEPTH-1:0] valid_inc;
  assign valid_inc = valid_w + LIST_DEPTH'(1);

  // Occupied slots always form a contiguous run from the front
  a_valid_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_w & valid_inc) == '0)
    else $error("cell valid bits not contiguous");

  // Held count tracks the number of occupied cells
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_w) == count_q)
    else $error("held count differs from occupied cells");

  // Keys are unique, so at most one cell hits
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_w))
    else $error("more than one cell matched the key");

  // An insert grows the list by exactly one
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !found && !full) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not grow the list");

  // A move or eviction leaves the held count unchanged
  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (found || full)) |=> $stable(count_q))
    else $error("held count changed without an insert");
`endif

endmodule
